// ===== design/w2ed_pkg.sv =====
// Package for the 802.11 to Ethernet decapsulator.
// Holds the shared constants and the queue entry type used by the front,
// queue and back modules.
`timescale 1ns / 1ps
`default_nettype none

package w2ed_pkg;

   // Ethernet header: destination, source, ethertype.
   localparam int HDR_BYTES   = 14;
   localparam int ENTRY_BITS  = 8 * HDR_BYTES;
   localparam int QUEUE_DEPTH = 4;

   // Byte position counter and its saturation point.
   localparam int          POS_BITS = 6;
   localparam logic [5:0]  POS_SAT  = 6'd40;

   // 802.11 header length pieces.
   localparam logic [5:0]  HDR_BASE_LEN = 6'd24;
   localparam logic [5:0]  ADDR4_EXTRA  = 6'd6;
   localparam logic [5:0]  QOS_EXTRA    = 6'd2;
   localparam logic [5:0]  LLC_LEN      = 6'd6;

   // Configuration register indexes.
   localparam logic CSR_STRICT_MODE = 1'b0;
   localparam logic CSR_INSERT_HDR  = 1'b1;

   // One queue entry: either a whole Ethernet header or one payload byte.
   // A payload byte sits in the top byte of data, where header byte 0 sits.
   typedef struct packed {
      logic                    is_hdr;
      logic                    last;
      logic [ENTRY_BITS-1:0]   data;
   } q_entry_type;

endpackage

`default_nettype wire

// ===== design/w2ed_front.sv =====
// Front part of the decapsulator: parses the 802.11 byte stream, holds the
// configuration registers and pushes header or payload entries to the queue.
// Depends on w2ed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w2ed_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_addr,
   input  wire logic                  csr_wdata,
   input  wire logic                  req_tvalid,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tuser,
   input  wire logic                  q_ready,
   output logic                       req_tready,
   output logic                       q_push,
   output w2ed_pkg::q_entry_type      q_entry
);

   logic        strict_ff, strict_in;
   logic        insert_ff, insert_in;
   logic [5:0]  pos_ff, pos_in;
   logic [7:0]  cb0_ff, cb0_in;
   logic [1:0]  dir_ff, dir_in;
   logic [5:0]  hl_ff, hl_in;
   logic        pad_ff, pad_in;
   logic        drop_ff, drop_in;
   logic [47:0] dest_ff, dest_in;
   logic [47:0] src_ff, src_in;
   logic [15:0] eth_ff, eth_in;

   logic        accept;
   logic        wep;
   logic        in_llc;
   logic        llc_miss;
   logic        drop_next;
   logic        push_hdr;
   logic        push_pay;
   logic [5:0]  llc_off;
   logic [5:0]  len_raw;
   logic [5:0]  len_pad;
   logic [1:0]  dslot;
   logic [1:0]  sslot;
   logic [1:0]  slot;
   logic        in_addr;

   // Expected LLC/SNAP byte for each offset into the LLC header.
   function automatic logic [7:0] snap_byte(input logic [2:0] off);
      logic [7:0] val;
      case (off)
         3'd0:    val = 8'hAA;
         3'd1:    val = 8'hAA;
         3'd2:    val = 8'h03;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;

   // Configuration writes.
   always_comb begin
      strict_in = strict_ff;
      insert_in = insert_ff;
      if (csr_we) begin
         case (csr_addr)
            w2ed_pkg::CSR_STRICT_MODE: strict_in = csr_wdata;
            w2ed_pkg::CSR_INSERT_HDR:  insert_in = csr_wdata;
            default:                   strict_in = strict_ff;
         endcase
      end
   end

   // Header length from the two control bytes and the pad flag.
   always_comb begin
      len_raw = w2ed_pkg::HDR_BASE_LEN;
      if (req_tdata[1:0] == 2'b11) begin
         len_raw = len_raw + w2ed_pkg::ADDR4_EXTRA;
      end
      if ((cb0_ff & 8'h8C) == 8'h88) begin
         len_raw = len_raw + w2ed_pkg::QOS_EXTRA;
      end
      len_pad = len_raw;
      if (pad_ff && (len_raw[1:0] != 2'b00)) begin
         len_pad = {len_raw[5:2] + 4'd1, 2'b00};
      end
   end

   // Address slot of this byte and the slots that feed destination and source.
   always_comb begin
      in_addr = (pos_ff >= 6'd4) && (pos_ff < 6'd22);
      if (pos_ff < 6'd10) begin
         slot = 2'd0;
      end else if (pos_ff < 6'd16) begin
         slot = 2'd1;
      end else begin
         slot = 2'd2;
      end
      dslot = (dir_ff == 2'd1) ? 2'd2 : 2'd0;
      sslot = (dir_ff == 2'd2) ? 2'd2 : 2'd1;
   end

   // Drop decision for the current byte.
   assign wep       = (pos_ff == 6'd1) && req_tdata[6];
   assign in_llc    = (pos_ff >= 6'd2) && (pos_ff >= hl_ff)
                      && (pos_ff < hl_ff + w2ed_pkg::LLC_LEN);
   assign llc_off   = pos_ff - hl_ff;
   assign llc_miss  = in_llc && strict_ff && (req_tdata != snap_byte(llc_off[2:0]));
   assign drop_next = drop_ff || wep || llc_miss;

   assign push_hdr = (pos_ff >= 6'd2) && !drop_next && insert_ff
                     && (pos_ff == hl_ff + 6'd7);
   assign push_pay = (pos_ff >= 6'd2) && !drop_next && (pos_ff >= hl_ff + 6'd8);

   // Entry toward the queue.
   always_comb begin
      q_push        = accept && (push_hdr || push_pay);
      q_entry.last  = req_tlast;
      q_entry.is_hdr = push_hdr;
      if (push_hdr) begin
         q_entry.data = {dest_ff, src_ff, eth_ff[7:0], req_tdata};
      end else begin
         q_entry.data = {req_tdata, {(w2ed_pkg::ENTRY_BITS - 8){1'b0}}};
      end
   end

   // Parser state update for each accepted item.
   always_comb begin
      pos_in  = pos_ff;
      cb0_in  = cb0_ff;
      dir_in  = dir_ff;
      hl_in   = hl_ff;
      pad_in  = pad_ff;
      drop_in = drop_ff;
      dest_in = dest_ff;
      src_in  = src_ff;
      eth_in  = eth_ff;
      if (accept) begin
         if (pos_ff == 6'd0) begin
            cb0_in = req_tdata;
            pad_in = req_tuser;
         end else if (pos_ff == 6'd1) begin
            dir_in = req_tdata[1:0];
            hl_in  = len_pad;
         end
         if (in_addr && (slot == dslot)) begin
            dest_in = {dest_ff[39:0], req_tdata};
         end
         if (in_addr && (slot == sslot)) begin
            src_in = {src_ff[39:0], req_tdata};
         end
         if ((pos_ff >= 6'd2) && ((pos_ff == hl_ff + 6'd6) || (pos_ff == hl_ff + 6'd7))) begin
            eth_in = {eth_ff[7:0], req_tdata};
         end
         if (req_tlast) begin
            pos_in  = '0;
            drop_in = 1'b0;
         end else begin
            pos_in  = (pos_ff < w2ed_pkg::POS_SAT) ? pos_ff + 6'd1 : w2ed_pkg::POS_SAT;
            drop_in = drop_next;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
         insert_ff <= 1'b1;
         pos_ff    <= '0;
         cb0_ff    <= '0;
         dir_ff    <= '0;
         hl_ff     <= w2ed_pkg::HDR_BASE_LEN;
         pad_ff    <= 1'b0;
         drop_ff   <= 1'b0;
      end else begin
         strict_ff <= strict_in;
         insert_ff <= insert_in;
         pos_ff    <= pos_in;
         cb0_ff    <= cb0_in;
         dir_ff    <= dir_in;
         hl_ff     <= hl_in;
         pad_ff    <= pad_in;
         drop_ff   <= drop_in;
      end
   end

   // Address and ethertype stores.
   always_ff @(posedge clock) begin
      dest_ff <= dest_in;
      src_ff  <= src_in;
      eth_ff  <= eth_in;
   end

endmodule

`default_nettype wire

// ===== design/w2ed_queue.sv =====
// Short queue between the parsing front and the output back.
// Holds header and payload entries; depends on w2ed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w2ed_queue #(
   parameter int DEPTH = w2ed_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire w2ed_pkg::q_entry_type push_entry,
   input  wire logic                  pop,
   output logic                       in_ready,
   output logic                       out_valid,
   output w2ed_pkg::q_entry_type      out_entry
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   w2ed_pkg::q_entry_type mem [DEPTH];

   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign in_ready  = (count_ff != CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = mem[rd_ptr_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/w2ed_back.sv =====
// Back part of the decapsulator: takes entries from the queue and sends them
// as output items, fourteen for a header entry and one for a payload entry.
// Depends on w2ed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module w2ed_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire w2ed_pkg::q_entry_type q_entry,
   input  wire logic                  rsp_tready,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast
);

   localparam logic [3:0] HDR_LAST = 4'(w2ed_pkg::HDR_BYTES - 1);

   w2ed_pkg::q_entry_type ent_ff, ent_in;
   logic                  vld_ff, vld_in;
   logic [3:0]            idx_ff, idx_in;
   logic                  fire;
   logic                  done;
   logic                  load;
   logic [6:0]            bit_off;

   assign fire    = vld_ff && rsp_tready;
   assign done    = !ent_ff.is_hdr || (idx_ff == HDR_LAST);
   assign load    = !vld_ff || (fire && done);
   assign q_pop   = load && q_valid;

   // Byte select: header byte 0 sits in the top byte of the entry.
   assign bit_off    = {HDR_LAST - idx_ff, 3'b000};
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = ent_ff.data[bit_off +: 8];
   assign rsp_tlast  = ent_ff.last && done;

   // Load a new entry or step through the header bytes.
   always_comb begin
      ent_in = ent_ff;
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (load) begin
         vld_in = q_valid;
         ent_in = q_entry;
         idx_in = '0;
      end else if (fire) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

`default_nettype wire

// ===== design/wifi_to_ethernet_decap_top.sv =====
// 802.11 to Ethernet decapsulator, byte-serial.
// Input channel req_*: one 802.11 frame byte per item, req_tlast on the
//   final byte, req_tuser the pad flag taken from the first byte.
// Output channel rsp_*: the Ethernet frame, optional 14-byte header then
//   payload, rsp_tlast on its final byte.
// Configuration: csr_we writes csr_wdata to register csr_addr
//   (0 strict LLC check, 1 header insertion); write only while idle.
// Throughput: one input item per cycle while the queue has space. A
//   payload byte is written into the queue, then loaded into the back
//   part's output register, from which it is presented on the output.
//   The Ethernet header is fourteen output items from one queue entry,
//   sent one after another by the back part; the input stalls only when
//   the queue between front and back is full, so the output port's one
//   byte per cycle while rsp_tready is high sets the long-run rate.
// Reset clears the parser, empties the queue, sets strict mode off and
//   header insertion on; no clearing pass is needed.
// When the receiver holds rsp_tready low, the output holds its item and
//   the queue fills; req_tready then falls until space frees up.
// Depends on w2ed_pkg, w2ed_front, w2ed_queue and w2ed_back.
`timescale 1ns / 1ps
`default_nettype none

module wifi_to_ethernet_decap_top #(
   parameter int QUEUE_DEPTH = w2ed_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic        csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   input  wire logic        req_tuser,   // [0] header_padded
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast
);

   w2ed_pkg::q_entry_type push_entry;
   w2ed_pkg::q_entry_type pop_entry;
   logic                  push;
   logic                  pop;
   logic                  q_ready;
   logic                  q_valid;

   // Parsing front.
   w2ed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .req_tready (req_tready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   // Entry queue.
   w2ed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .in_ready   (q_ready),
      .out_valid  (q_valid),
      .out_entry  (pop_entry)
   );

   // Output back.
   w2ed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (pop_entry),
      .rsp_tready (rsp_tready),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== test/wifi_to_ethernet_decap_top_test.sv =====
// Self-checking testbench for the byte-serial 802.11 to Ethernet decapsulator.
// Frames are built in the bench, the expected Ethernet bytes come from a local
// model of the parser, and each output item is checked in order. Needs w2ed_pkg.
`timescale 1ns / 1ps

module wifi_to_ethernet_decap_top_test;

   // Frame control decoding constants.
   localparam logic [7:0] FC0_QOS_MASK = 8'h8C;
   localparam logic [7:0] FC0_QOS_DATA = 8'h88;
   localparam int         FC1_WEP_BIT  = 6;
   localparam logic [7:0] SNAP_HDR [6] = '{8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h00};

   // Run control.
   localparam int DRAIN_TAIL   = 40;
   localparam int STALL_LIMIT  = 1000;
   localparam int PHASE_ITEMS  = 20;

   typedef enum logic [1:0] {
      DS_NONE = 2'd0,
      DS_TO   = 2'd1,
      DS_FROM = 2'd2,
      DS_WDS  = 2'd3
   } ds_dir_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } eth_byte_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       csr_we     = 1'b0;
   logic       csr_addr   = 1'b0;
   logic       csr_wdata  = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       req_tuser  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   wifi_to_ethernet_decap_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Expected Ethernet bytes, oldest first.
   eth_byte_type eth_expected [$];

   // Local copy of the parser state and the registers.
   logic [5:0]  parse_pos   = '0;
   logic [7:0]  fc_zero     = '0;
   logic [7:0]  fc_one      = '0;
   int          wifi_hdr_len = 24;
   logic [47:0] dest_mac    = '0;
   logic [47:0] src_mac     = '0;
   logic [15:0] eth_type    = '0;
   logic        frame_drop  = 1'b0;
   logic        pad_seen    = 1'b0;
   logic        strict_llc  = 1'b0;
   logic        insert_hdr  = 1'b1;

   int error_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // 802.11 header length from the two control bytes and the pad flag.
   function automatic int hdr_len_of(logic [7:0] c0, logic [7:0] c1, logic padded);
      int len;
      len = w2ed_pkg::HDR_BASE_LEN;
      if (c1[1:0] == DS_WDS) len += w2ed_pkg::ADDR4_EXTRA;
      if ((c0 & FC0_QOS_MASK) == FC0_QOS_DATA) len += w2ed_pkg::QOS_EXTRA;
      if (padded && (len % 4) != 0) len += 4 - (len % 4);
      return len;
   endfunction

   // Advance the parser by one accepted input item and queue its Ethernet bytes.
   function automatic void decap_predict(logic [7:0] b, logic fin, logic pad_in);
      int p;
      int hl;
      int slot;
      int dslot;
      int sslot;
      p = parse_pos;
      if (p == 0) begin
         fc_zero  = b;
         pad_seen = pad_in;
      end else if (p == 1) begin
         fc_one       = b;
         wifi_hdr_len = hdr_len_of(fc_zero, b, pad_seen);
         if (b[FC1_WEP_BIT]) frame_drop = 1'b1;
      end
      hl = wifi_hdr_len;

      if (!frame_drop && p >= 2) begin
         // Address capture according to the direction bits.
         if (p >= 4 && p < 22) begin
            slot  = (p - 4) / 6;
            dslot = (fc_one[1:0] == DS_TO) ? 2 : 0;
            sslot = (fc_one[1:0] == DS_FROM) ? 2 : 1;
            if (slot == dslot) dest_mac = {dest_mac[39:0], b};
            if (slot == sslot) src_mac = {src_mac[39:0], b};
         end
         // LLC/SNAP check, then the ethertype.
         if (p >= hl && p < hl + w2ed_pkg::LLC_LEN) begin
            if (strict_llc && b != SNAP_HDR[p - hl]) frame_drop = 1'b1;
         end else if (p == hl + 6 || p == hl + 7) begin
            eth_type = {eth_type[7:0], b};
         end

         if (!frame_drop) begin
            if (p == hl + 7) begin
               if (insert_hdr) begin
                  for (int i = 0; i < 6; i++)
                     eth_expected.push_back('{dest_mac[8*(5-i) +: 8], 1'b0});
                  for (int i = 0; i < 6; i++)
                     eth_expected.push_back('{src_mac[8*(5-i) +: 8], 1'b0});
                  eth_expected.push_back('{eth_type[15:8], 1'b0});
                  eth_expected.push_back('{eth_type[7:0], fin});
               end
            end else if (p >= hl + 8) begin
               eth_expected.push_back('{b, fin});
            end
         end
      end

      // A frame end restarts the parser.
      if (fin) begin
         parse_pos  = '0;
         frame_drop = 1'b0;
      end else if (parse_pos < w2ed_pkg::POS_SAT) begin
         parse_pos = parse_pos + 6'd1;
      end
   endfunction

   // Receiver side: random back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare each output item with the oldest expected byte.
   always @(posedge clock) begin
      eth_byte_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (eth_expected.size() == 0) begin
            $error("unexpected output item: out_byte %02h out_last %0b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            exp_item = eth_expected.pop_front();
            if (rsp_tdata !== exp_item.data) begin
               $error("out_byte mismatch: expected %02h, actual %02h", exp_item.data, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== exp_item.last) begin
               $error("out_last mismatch: expected %0b, actual %0b", exp_item.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Send one frame byte, with a random idle gap in front of it.
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic pad_flag);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      req_tuser  <= pad_flag;
      do @(posedge clock); while (!req_tready);
      decap_predict(b, fin, pad_flag);
      items_sent++;
   endtask

   // Build a frame: header, LLC/SNAP, ethertype, payload; optionally cut short.
   task automatic send_frame(input logic [7:0] c0, input logic [7:0] c1, input logic padded,
                             input int payload_len, input bit bad_llc, input int cut);
      logic [7:0] frm [$];
      int hl;
      int k;
      int n;
      hl = hdr_len_of(c0, c1, padded);
      frm.push_back(c0);
      frm.push_back(c1);
      while (frm.size() < hl) frm.push_back(8'($urandom));
      for (k = 0; k < 6; k++) frm.push_back(SNAP_HDR[k]);
      if (bad_llc) begin
         k = $urandom_range(5);
         frm[hl + k] = frm[hl + k] ^ 8'($urandom_range(1, 255));
      end
      for (k = 0; k < 2 + payload_len; k++) frm.push_back(8'($urandom));
      n = (cut > 0 && cut < frm.size()) ? cut : frm.size();
      for (k = 0; k < n; k++)
         send_byte(frm[k], k == n - 1, (k == 0) ? padded : 1'($urandom));
   endtask

   // Hold the sender until all expected bytes are out and the block is quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (eth_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input logic addr, input logic value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (addr == w2ed_pkg::CSR_STRICT_MODE) strict_llc = value;
      else insert_hdr = value;
   endtask

   // Control bytes all ones but the WEP bit: four addresses, padded to 32. Then
   // all-zero control bytes, a bad LLC with the strict check off, and an
   // empty payload, so only the Ethernet header comes out.
   task automatic test_field_extremes();
      send_frame(8'hFF, 8'hBF, 1'b1, 1, 1'b0, 0);
      send_frame(8'h00, 8'h00, 1'b0, 0, 1'b1, 0);
   endtask

   // A frame ending on the ethertype with header insertion off emits nothing.
   task automatic test_empty_payload();
      wait_idle();
      write_csr(w2ed_pkg::CSR_INSERT_HDR, 1'b0);
      send_frame(8'h08, {6'h00, DS_FROM}, 1'b0, 0, 1'b0, 0);
      wait_idle();
      write_csr(w2ed_pkg::CSR_INSERT_HDR, 1'b1);
   endtask

   // A WEP frame cut short, a one-byte frame and a frame that ends on the first ethertype byte.
   task automatic test_dropped_frames();
      send_frame(8'h08, 8'h41, 1'b0, 1, 1'b0, 6);
      send_byte(8'h5A, 1'b1, 1'b1);
      send_frame(8'h08, {6'h00, DS_FROM}, 1'b0, 1, 1'b0, w2ed_pkg::HDR_BASE_LEN + 7);
   endtask

   // Strict LLC check: a clean frame passes, a bad QoS frame is dropped.
   task automatic test_strict_llc();
      wait_idle();
      write_csr(w2ed_pkg::CSR_STRICT_MODE, 1'b1);
      send_frame(8'h08, {6'h00, DS_TO}, 1'b0, 1, 1'b0, 0);
      send_frame(8'h88, {6'h00, DS_NONE}, 1'b0, 1, 1'b1, 0);
      wait_idle();
      write_csr(w2ed_pkg::CSR_STRICT_MODE, 1'b0);
   endtask

   // Mostly well-formed frames with random content, some noise frames.
   task automatic send_random_frame();
      logic [7:0] c0;
      logic [7:0] c1;
      int len;
      if ($urandom_range(99) < 20) begin
         len = $urandom_range(1, 45);
         for (int k = 0; k < len; k++)
            send_byte(8'($urandom), k == len - 1, 1'($urandom));
      end else begin
         c0 = 8'($urandom);
         if ($urandom_range(1)) c0 = (c0 & ~FC0_QOS_MASK) | FC0_QOS_DATA;
         else if ((c0 & FC0_QOS_MASK) == FC0_QOS_DATA) c0 = c0 ^ 8'h80;
         c1 = 8'($urandom);
         c1[FC1_WEP_BIT] = ($urandom_range(99) < 10);
         send_frame(c0, c1, 1'($urandom), $urandom_range(0, 6),
                    $urandom_range(99) < 15,
                    ($urandom_range(99) < 10) ? $urandom_range(1, 33) : 0);
      end
   endtask

   // One random phase with a given idle pattern and register setting.
   task automatic test_random_phase(input int idle_s, input int idle_r,
                                    input logic strict_v, input logic insert_v);
      int start;
      wait_idle();
      write_csr(w2ed_pkg::CSR_STRICT_MODE, strict_v);
      write_csr(w2ed_pkg::CSR_INSERT_HDR, insert_v);
      send_idle_pct = idle_s;
      stall_pct     = idle_r;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         send_random_frame();
         // From half of the phase on, let the output run dry after each frame.
         if (items_sent - start >= PHASE_ITEMS / 2 && items_sent - start < PHASE_ITEMS / 2 + 45)
            wait_idle();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // No idling on either side.
      test_field_extremes();

      // Sender idle in most cycles.
      send_idle_pct = 59;
      stall_pct     = 0;
      test_dropped_frames();
      test_empty_payload();

      // Receiver stalling in most cycles.
      send_idle_pct = 0;
      stall_pct     = 59;
      test_strict_llc();

      // Both sides idle now and then, random frames without the header.
      test_random_phase(18, 18, 1'b0, 1'b0);

      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
